// ===== hw/rtl/rrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrf_pkg: shared types and constants of the request framer
// Parse phases, result codes, token bytes and the structs passed between
// the configuration block, the parse core and the output stage.
// ----------------------------------------------------------------------------
package rrf_pkg;

   // parse phases, one-hot
   typedef enum logic [7:0] {
      PH_ASTERISK = 8'b0000_0001,
      PH_COUNT    = 8'b0000_0010,
      PH_CR       = 8'b0000_0100,
      PH_LF       = 8'b0000_1000,
      PH_DOLLAR   = 8'b0001_0000,
      PH_LENGTH   = 8'b0010_0000,
      PH_PAYLOAD  = 8'b0100_0000,
      PH_COMPLETE = 8'b1000_0000
   } phase_type;

   localparam logic [1:0] KIND_FRAMING  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
   localparam logic [1:0] KIND_COMPLETE = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_TOKEN  = 2'd1;
   localparam logic [1:0] ERR_COUNT  = 2'd2;
   localparam logic [1:0] ERR_LENGTH = 2'd3;

   localparam logic [7:0] CHAR_ASTERISK = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   // register indexes
   localparam logic REG_MAX_ARGUMENTS       = 1'b0;
   localparam logic REG_MAX_ARGUMENT_LENGTH = 1'b1;

   localparam logic [7:0]  MAX_ARGUMENTS_RESET       = 8'd255;
   localparam logic [31:0] MAX_ARGUMENT_LENGTH_RESET = 32'd536870912;

   typedef struct packed {
      logic [7:0]  max_arguments;
      logic [31:0] max_argument_length;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  byte_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  argument_index;
      logic [31:0] byte_offset;
      logic        last_of_argument;
      logic [7:0]  argument_count;
      logic [1:0]  error_code;
   } result_type;

endpackage

// ===== hw/rtl/rrf_csr.sv =====
// ----------------------------------------------------------------------------
// rrf_csr: configuration registers
// Holds the argument count and argument length limits behind a simple
// APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module rrf_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output rrf_pkg::cfg_type cfg
);
   import rrf_pkg::*;

   logic [7:0]  max_args_ff, max_args_in;
   logic [31:0] max_len_ff, max_len_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      max_args_in = max_args_ff;
      max_len_in  = max_len_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MAX_ARGUMENTS:       max_args_in = csr_pwdata[7:0];
            REG_MAX_ARGUMENT_LENGTH: max_len_in  = csr_pwdata;
            default:                 max_len_in  = max_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= MAX_ARGUMENTS_RESET;
         max_len_ff  <= MAX_ARGUMENT_LENGTH_RESET;
      end else begin
         max_args_ff <= max_args_in;
         max_len_ff  <= max_len_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAX_ARGUMENTS:       csr_prdata = {24'd0, max_args_ff};
         REG_MAX_ARGUMENT_LENGTH: csr_prdata = max_len_ff;
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign cfg.max_arguments       = max_args_ff;
   assign cfg.max_argument_length = max_len_ff;

endmodule

// ===== hw/rtl/rrf_core.sv =====
// ----------------------------------------------------------------------------
// rrf_core: parse state and per-byte classification
// Classifies the incoming byte against the current phase and advances
// the phase, count, length, argument and offset registers on each word.
// ----------------------------------------------------------------------------
module rrf_core #(
   parameter int LENGTH_WIDTH = 32,
   parameter int COUNT_WIDTH  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  rrf_pkg::cfg_type    cfg,
   output rrf_pkg::result_type result
);
   import rrf_pkg::*;

   // stored widths: the 8-bit and 32-bit limit registers cap the values anyway
   localparam int LW = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;
   localparam int CW = (COUNT_WIDTH < 8) ? COUNT_WIDTH : 8;

   phase_type       phase_ff, phase_in;
   phase_type       after_ff, after_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [7:0]      cur_ff, cur_in;
   logic [LW-1:0]   len_ff, len_in;
   logic [LW-1:0]   off_ff, off_in;

   logic            is_digit;
   logic [3:0]      digit_val;
   logic [CW+3:0]   count_ext, count_next;
   logic            count_over;
   logic [LW+3:0]   len_ext, len_next;
   logic            len_over;
   logic [LW-1:0]   off_plus;
   logic [7:0]      cur_plus;
   logic            finish;
   logic [1:0]      err;

   assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign digit_val = data_byte[3:0];

   // times ten as two shifted adds
   assign count_ext  = (CW+4)'(count_ff);
   assign count_next = (count_ext << 3) + (count_ext << 1) + (CW+4)'(digit_val);
   assign count_over = (12'(count_next) > 12'(cfg.max_arguments))
                       || (count_next[CW+3:CW] != 4'd0);

   assign len_ext  = (LW+4)'(len_ff);
   assign len_next = (len_ext << 3) + (len_ext << 1) + (LW+4)'(digit_val);
   assign len_over = (36'(len_next) > 36'(cfg.max_argument_length))
                     || (len_next[LW+3:LW] != 4'd0);

   assign off_plus = off_ff + LW'(1);
   assign cur_plus = cur_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      after_in = after_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      len_in   = len_ff;
      off_in   = off_ff;
      finish   = 1'b0;
      err      = ERR_NONE;
      result.byte_kind        = KIND_FRAMING;
      result.payload_byte     = 8'd0;
      result.argument_index   = 8'd0;
      result.byte_offset      = 32'd0;
      result.last_of_argument = 1'b0;

      unique case (phase_ff)
         PH_COUNT: begin
            if (is_digit) begin
               if (count_over) err = ERR_COUNT;
               else            count_in = count_next[CW-1:0];
            end else if (count_ff == '0) begin
               err = ERR_COUNT;
            end else begin
               phase_in = PH_LF;
               after_in = PH_DOLLAR;
               cur_in   = 8'd0;
            end
         end
         PH_CR: begin
            if (data_byte == CHAR_CR) phase_in = PH_LF;
            else                      err = ERR_TOKEN;
         end
         PH_LF: begin
            if (data_byte != CHAR_LF) begin
               err = ERR_TOKEN;
            end else if (after_ff == PH_COMPLETE) begin
               result.byte_kind = KIND_COMPLETE;
               phase_in = PH_ASTERISK;
               after_in = PH_ASTERISK;
            end else if (after_ff == PH_PAYLOAD && len_ff == '0) begin
               // empty argument ends on its line feed
               result.last_of_argument = 1'b1;
               result.argument_index   = cur_ff;
               finish = 1'b1;
            end else begin
               phase_in = after_ff;
            end
         end
         PH_DOLLAR: begin
            if (data_byte == CHAR_DOLLAR) begin
               len_in   = '0;
               phase_in = PH_LENGTH;
            end else if (data_byte == CHAR_CR) begin
               // bare CR: take the line end, then the length without a dollar
               len_in   = '0;
               phase_in = PH_LF;
               after_in = PH_LENGTH;
            end else begin
               err = ERR_TOKEN;
            end
         end
         PH_LENGTH: begin
            if (is_digit) begin
               if (len_over) err = ERR_LENGTH;
               else          len_in = len_next[LW-1:0];
            end else begin
               phase_in = PH_LF;
               after_in = PH_PAYLOAD;
               off_in   = '0;
            end
         end
         PH_PAYLOAD: begin
            result.byte_kind      = KIND_PAYLOAD;
            result.payload_byte   = data_byte;
            result.argument_index = cur_ff;
            result.byte_offset    = 32'(off_ff);
            off_in = off_plus;
            if (off_plus >= len_ff) begin
               result.last_of_argument = 1'b1;
               finish = 1'b1;
            end
         end
         default: begin
            // expecting the request marker
            if (data_byte == CHAR_ASTERISK) begin
               count_in = '0;
               phase_in = PH_COUNT;
            end else begin
               phase_in = PH_ASTERISK;
               err = ERR_TOKEN;
            end
         end
      endcase

      if (finish) begin
         cur_in   = cur_plus;
         phase_in = PH_CR;
         after_in = (cur_plus < 8'(count_ff)) ? PH_DOLLAR : PH_COMPLETE;
      end

      // any error: drop the request, keep the accumulators
      if (err != ERR_NONE) begin
         result.byte_kind        = KIND_ERROR;
         result.payload_byte     = 8'd0;
         result.argument_index   = 8'd0;
         result.byte_offset      = 32'd0;
         result.last_of_argument = 1'b0;
         phase_in = PH_ASTERISK;
         after_in = PH_ASTERISK;
      end

      result.argument_count = 8'(count_in);
      result.error_code     = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ASTERISK;
         after_ff <= PH_ASTERISK;
         count_ff <= '0;
         cur_ff   <= 8'd0;
         len_ff   <= '0;
         off_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         after_ff <= after_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
      end
   end

   a_error_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && result.byte_kind == KIND_ERROR) |=> (phase_ff == PH_ASTERISK))
      else $error("parser did not return to request start after an error");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (off_ff < len_ff))
      else $error("payload offset reached argument length");

   a_argument_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (cur_ff < 8'(count_ff)))
      else $error("argument index beyond argument count");

endmodule

// ===== hw/rtl/rrf_out_buf.sv =====
// ----------------------------------------------------------------------------
// rrf_out_buf: result register with skid stage
// Holds classified results for the output channel; the skid entry lets the
// input side take one more word in the cycle the output stalls.
// ----------------------------------------------------------------------------
module rrf_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rrf_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rrf_pkg::result_type out_data
);
   import rrf_pkg::*;

   logic       main_vld_ff, main_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_free;

   assign in_ready  = !skid_vld_ff;
   assign main_free = out_ready || !main_vld_ff;

   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (main_free) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            main_vld_in = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            main_in     = in_data;
            main_vld_in = in_valid;
         end
      end else if (in_valid && in_ready) begin
         // output stalled: park the word
         skid_in     = in_data;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_vld_ff;
   assign out_data  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> main_vld_ff)
      else $error("skid entry held while result register empty");

   a_stall_parks: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && main_vld_ff && !out_ready) |=> skid_vld_ff)
      else $error("word taken during stall was not parked");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && out_ready) |=> (main_vld_ff && !skid_vld_ff))
      else $error("skid entry did not move to result register");

endmodule

// ===== hw/rtl/resp_request_framer.sv =====
// ----------------------------------------------------------------------------
// resp_request_framer: array-of-bulk-strings request framer
// Takes one request byte per word and returns one classification word per
// byte: framing, payload with argument index and offset, completion, error.
// ----------------------------------------------------------------------------
// Each result word is registered: in the result register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while req_tready is high; the parse state updates in the accept cycle.
// A skid entry behind the result register keeps req_tready high while the
// output stalls, until the skid entry itself is full.
// Reset (synchronous) returns the parser to expect '*' and loads the limits
// with 255 arguments and 536870912 bytes; no clearing pass is needed.
module resp_request_framer #(
   parameter int LENGTH_WIDTH = 32,
   parameter int COUNT_WIDTH  = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] payload_byte, [15:8] argument_index,
                                    // [47:16] byte_offset, [55:48] argument_count,
                                    // [57:56] error_code, [63:58] zero
   output logic [1:0]  rsp_tuser,   // [1:0] byte_kind
   output logic        rsp_tlast,   // last_of_argument
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rrf_pkg::*;

   cfg_type    cfg;
   result_type core_res;
   result_type out_res;
   logic       take;

   assign take = req_tvalid && req_tready;

   rrf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rrf_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .cfg       (cfg),
      .result    (core_res)
   );

   rrf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata = {6'd0, out_res.error_code, out_res.argument_count,
                       out_res.byte_offset, out_res.argument_index,
                       out_res.payload_byte};
   assign rsp_tuser = out_res.byte_kind;
   assign rsp_tlast = out_res.last_of_argument;

endmodule
